[sv/clock_offset_latency_estimator_defines.svh]
// Assertion macros for the clock offset and latency estimator.
// Each use names a label, a property body and a message; clk and rst_n
// are taken from the module that uses the macro.
`ifndef CLOCK_OFFSET_LATENCY_ESTIMATOR_DEFINES_SVH
`define CLOCK_OFFSET_LATENCY_ESTIMATOR_DEFINES_SVH
`ifndef SYNTH
`define COLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define COLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define COLE_ASSERT(lbl, prop, msg)
`define COLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/cole_pkg.sv]
package cole_pkg;
  localparam int TS_W        = 16;
  localparam int FULL_W      = 63;
  localparam int OFS_W       = 64;
  localparam int WINDOW_SIZE = 8;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W       = OFS_W + WIN_AW;
  localparam int DIVC_W      = $clog2(SUM_W + 1);
  localparam int IN_W        = 208;
  localparam int OUT_W       = 152;
  localparam int CFG_AW      = 1;

  localparam logic [1:0] ACT_SYNC    = 2'd0;
  localparam logic [1:0] ACT_PACK    = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  localparam logic [CFG_AW-1:0] REG_DEFAULT_LATENCY = 1'd0;
  localparam logic [CFG_AW-1:0] REG_NO_LATENCY_CODE = 1'd1;
endpackage

[sv/clock_offset_latency_estimator.sv]
// Clock offset and one-way latency estimator. Each input transfer carries one
// action in in_tuser: a received sync record, a pack request or a corrector
// latency query; every action produces exactly one result transfer with the
// current status. Packs, queries and sync records that measure no round trip
// pass from acceptance through the calculation state to the result. A sync
// record that measures a round trip also writes its offset to the window,
// sums the n window entries (n from 1 to 8) one entry per cycle from the
// offset memory, and forms the signed mean with a restoring divider, one
// quotient bit per cycle (67 quotient bits), before the result. The block
// takes a new item only when the previous one is done; a finished result
// waits in the output register without blocking acceptance, but the next
// result stalls in its final state until that register is free. No clearing
// pass is needed after reset.
module clock_offset_latency_estimator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // peer_timestamp, latency_corrector, peer_latency, peer_full_time,
  // echoed_flag, echoed_timestamp, receive_timestamp, local_full_time, pad
  input  logic [cole_pkg::IN_W-1:0]     in_tdata,
  // action
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // latency_valid, latency, round_trip, other_latency_valid, other_latency,
  // offset_valid, mean_offset, include_external, external_timestamp,
  // corrector_valid, corrector_latency, pad
  output logic [cole_pkg::OUT_W-1:0]    out_tdata,
  input  logic                          cfg_we,
  input  logic [cole_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [15:0]                   cfg_wdata
);
`include "clock_offset_latency_estimator_defines.svh"

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CALC   = 4'd1;
  localparam logic [3:0] ST_OFFS   = 4'd2;
  localparam logic [3:0] ST_SUM    = 4'd3;
  localparam logic [3:0] ST_ABS    = 4'd4;
  localparam logic [3:0] ST_DIV    = 4'd5;
  localparam logic [3:0] ST_SIGN   = 4'd6;
  localparam logic [3:0] ST_FINISH = 4'd7;

  localparam int TW = cole_pkg::TS_W;
  localparam int FW = cole_pkg::FULL_W;
  localparam int OW = cole_pkg::OFS_W;
  localparam int SW = cole_pkg::SUM_W;
  localparam int AW = cole_pkg::WIN_AW;
  localparam int CW = cole_pkg::CNT_W;

  logic [3:0] state_r;

  // Configuration registers.
  logic [TW-1:0] default_latency_r, no_latency_code_r;

  // Latched input item.
  logic [1:0]    act_r;
  logic [TW-1:0] peer_ts_r, corr_in_r, plat_in_r, echo_ts_r, recv_ts_r;
  logic [FW-1:0] peer_full_r, local_full_r;
  logic          echo_flag_r;

  // Estimator state.
  logic          corr_pend_r, ext_pend_r, lat_known_r, peer_known_r, mean_known_r;
  logic [TW-1:0] corr_time_r, ext_time_r, lat_val_r, rtt_r, peer_lat_r;
  logic [OW-1:0] mean_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] wr_ptr_r;

  // Per-item result flags.
  logic          inc_ext_r, corr_valid_r;
  logic [TW-1:0] ext_ts_r, corr_lat_r;

  // Datapath of the offset mean.
  logic [OW-1:0] diff_r;
  logic [OW-1:0] win_mem [cole_pkg::WINDOW_SIZE];
  logic [OW-1:0] mem_q_r;
  logic [CW-1:0] rd_idx_r;
  logic          rd_vld_r;
  logic [SW-1:0] acc_r;
  logic          neg_r;
  logic [SW-1:0] quo_r;
  logic [CW-1:0] rem_r;
  logic [cole_pkg::DIVC_W-1:0] div_cnt_r;

  logic          out_valid_r;
  logic [cole_pkg::OUT_W-1:0] out_data_r;

  // Combinational helpers.
  logic          finished;
  logic [TW-1:0] rtt_nxt, lat_nxt;
  logic [OW-1:0] offset_nxt;
  logic [CW:0]   trial;
  logic          trial_ge;
  logic          in_xfer;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign finished   = !corr_pend_r;
  // Timestamps are 16 bits and the wrap is 2^16, so the modular
  // difference is a plain 16-bit subtraction.
  assign rtt_nxt    = recv_ts_r - echo_ts_r;
  assign lat_nxt    = (rtt_nxt < corr_in_r) ? default_latency_r
                                            : TW'((rtt_nxt - corr_in_r) >> 1);
  assign offset_nxt = diff_r + {{(OW-TW){1'b0}}, lat_val_r};
  assign trial      = {rem_r, quo_r[SW-1]};
  assign trial_ge   = (trial >= {1'b0, count_r});

  // Offset window: a circular buffer. The mean does not depend on the order
  // of the entries, so the oldest entry is simply overwritten when full.
  always_ff @(posedge clk) begin
    if (state_r == ST_OFFS) begin
      win_mem[wr_ptr_r] <= offset_nxt;
    end
    mem_q_r <= win_mem[rd_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      default_latency_r <= 16'd50;
      no_latency_code_r <= 16'hFFFF;
      corr_pend_r       <= 1'b0;
      corr_time_r       <= '0;
      ext_pend_r        <= 1'b0;
      ext_time_r        <= '0;
      lat_known_r       <= 1'b0;
      lat_val_r         <= '0;
      rtt_r             <= '0;
      peer_known_r      <= 1'b0;
      peer_lat_r        <= '0;
      count_r           <= '0;
      wr_ptr_r          <= '0;
      mean_known_r      <= 1'b0;
      mean_r            <= '0;
      out_valid_r       <= 1'b0;
      rd_vld_r          <= 1'b0;
      inc_ext_r         <= 1'b0;
      corr_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          cole_pkg::REG_DEFAULT_LATENCY: default_latency_r <= cfg_wdata;
          cole_pkg::REG_NO_LATENCY_CODE: no_latency_code_r <= cfg_wdata;
          default: ;
        endcase
      end
      // The final state loads the next result itself when the register drains.
      if (out_valid_r && out_tready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            act_r        <= in_tuser;
            peer_ts_r    <= in_tdata[15:0];
            corr_in_r    <= in_tdata[31:16];
            plat_in_r    <= in_tdata[47:32];
            peer_full_r  <= in_tdata[110:48];
            echo_flag_r  <= in_tdata[111];
            echo_ts_r    <= in_tdata[127:112];
            recv_ts_r    <= in_tdata[143:128];
            local_full_r <= in_tdata[206:144];
            inc_ext_r    <= 1'b0;
            ext_ts_r     <= '0;
            corr_valid_r <= 1'b0;
            corr_lat_r   <= '0;
            state_r      <= ST_CALC;
          end
        end
        ST_CALC: begin
          state_r <= ST_FINISH;
          case (act_r)
            cole_pkg::ACT_SYNC: begin
              if (finished) begin
                ext_time_r <= peer_ts_r;
                ext_pend_r <= 1'b1;
              end
              if (plat_in_r != no_latency_code_r) begin
                peer_known_r <= 1'b1;
                peer_lat_r   <= plat_in_r;
              end
              if (echo_flag_r && finished) begin
                corr_pend_r <= 1'b1;
                corr_time_r <= recv_ts_r;
                if (corr_in_r != no_latency_code_r) begin
                  rtt_r       <= rtt_nxt;
                  lat_val_r   <= lat_nxt;
                  lat_known_r <= 1'b1;
                  diff_r      <= {1'b0, local_full_r} - {1'b0, peer_full_r};
                  state_r     <= ST_OFFS;
                end
              end
            end
            cole_pkg::ACT_PACK: begin
              if (ext_pend_r) begin
                inc_ext_r  <= 1'b1;
                ext_ts_r   <= ext_time_r;
                ext_pend_r <= 1'b0;
              end
            end
            cole_pkg::ACT_QUERY: begin
              if (corr_pend_r) begin
                corr_valid_r <= 1'b1;
                corr_lat_r   <= recv_ts_r - corr_time_r;
                corr_pend_r  <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        ST_OFFS: begin
          if (count_r < CW'(cole_pkg::WINDOW_SIZE)) begin
            count_r <= count_r + 1'b1;
          end
          if (wr_ptr_r == AW'(cole_pkg::WINDOW_SIZE - 1)) begin
            wr_ptr_r <= '0;
          end else begin
            wr_ptr_r <= wr_ptr_r + 1'b1;
          end
          rd_idx_r <= '0;
          rd_vld_r <= 1'b0;
          acc_r    <= '0;
          state_r  <= ST_SUM;
        end
        ST_SUM: begin
          // One read issued per cycle; data arrives from the registered read in the next cycle.
          if (rd_vld_r) begin
            acc_r <= acc_r + {{(SW-OW){mem_q_r[OW-1]}}, mem_q_r};
          end
          if (rd_idx_r < count_r) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
            if (!rd_vld_r) begin
              state_r <= ST_ABS;
            end
          end
        end
        ST_ABS: begin
          neg_r     <= acc_r[SW-1];
          quo_r     <= acc_r[SW-1] ? (~acc_r + 1'b1) : acc_r;
          rem_r     <= '0;
          div_cnt_r <= '0;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          // Restoring division of the magnitude by the entry count.
          if (div_cnt_r == cole_pkg::DIVC_W'(SW)) begin
            state_r <= ST_SIGN;
          end else begin
            rem_r     <= trial_ge ? CW'(trial - {1'b0, count_r}) : CW'(trial);
            quo_r     <= {quo_r[SW-2:0], trial_ge};
            div_cnt_r <= div_cnt_r + 1'b1;
          end
        end
        ST_SIGN: begin
          mean_r       <= neg_r ? (~quo_r[OW-1:0] + 1'b1) : quo_r[OW-1:0];
          mean_known_r <= 1'b1;
          state_r      <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'b000,
                            corr_lat_r, corr_valid_r,
                            ext_ts_r, inc_ext_r,
                            mean_known_r ? mean_r : {OW{1'b0}}, mean_known_r,
                            peer_known_r ? peer_lat_r : {TW{1'b0}}, peer_known_r,
                            lat_known_r ? rtt_r : {TW{1'b0}},
                            lat_known_r ? lat_val_r : no_latency_code_r,
                            lat_known_r};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `COLE_ASSERT(a_accept_starts, in_xfer |=> state_r == ST_CALC, "accepted item did not start")
  `COLE_ASSERT(a_count_bound, count_r <= CW'(cole_pkg::WINDOW_SIZE), "window count overflow")
  `COLE_ASSERT(a_div_bound, state_r == ST_DIV |-> div_cnt_r <= cole_pkg::DIVC_W'(SW), "divider overrun")
  `COLE_ASSERT(a_out_from_finish, $rose(out_valid_r) |-> $past(state_r) == ST_FINISH, "result outside finish")
  `COLE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == ST_IDLE && !out_valid_r, "reset not idle")
endmodule
